FILE: src/bfh_pkg.sv
// ----------------------------------------------------------------------------
// bfh_pkg
// Shared types and constants of the back/forward location history: ring
// depth, index and count widths, the packed location word, and the control
// and status groups that pass between the top level and the ring units.
// ----------------------------------------------------------------------------
`default_nettype none

package bfh_pkg;

    // Number of locations each ring holds (legal range 2 to 256).
    localparam int HISTORY_DEPTH = 16;

    // Ring index and fill count widths.
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // Field widths of one location.
    localparam int FILE_W = 8;
    localparam int LINE_W = 24;
    localparam int CMD_W  = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RECORD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BACK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd2;

    // One stored location, file id in the upper byte.
    typedef struct packed {
        logic [FILE_W-1:0] file_id;
        logic [LINE_W-1:0] line_num;
    } loc_t;

    localparam int LOC_W = $bits(loc_t);

    // Operation applied to one ring when a command executes.
    typedef enum logic [1:0] {
        RING_NONE  = 2'd0,
        RING_PUSH  = 2'd1,
        RING_POP   = 2'd2,
        RING_CLEAR = 2'd3
    } ring_op_t;

    // Control from the sequencer to a ring.
    typedef struct packed {
        logic     rd;    // read the newest entry
        logic     fire;  // apply op this cycle
        ring_op_t op;
    } ring_ctl_t;

    // Status from a ring back to the sequencer.
    typedef struct packed {
        logic nonempty;
        loc_t top_data;
    } ring_sts_t;

endpackage

`default_nettype wire

FILE: src/bfh_in_if.sv
// ----------------------------------------------------------------------------
// bfh_in_if
// Command channel: one word carries a command and the current location.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfh_in_if;

    logic                       valid;
    logic                       ready;
    logic [bfh_pkg::CMD_W-1:0]  cmd;
    logic [bfh_pkg::FILE_W-1:0] file_id;
    logic [bfh_pkg::LINE_W-1:0] line_num;

    modport source (output valid, output cmd, output file_id, output line_num,
                    input ready);
    modport sink   (input valid, input cmd, input file_id, input line_num,
                    output ready);

endinterface

`default_nettype wire

FILE: src/bfh_out_if.sv
// ----------------------------------------------------------------------------
// bfh_out_if
// Result channel: one word carries the hit flag and the returned location.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfh_out_if;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [bfh_pkg::FILE_W-1:0] out_file_id;
    logic [bfh_pkg::LINE_W-1:0] out_line_num;

    modport source (output valid, output found, output out_file_id,
                    output out_line_num, input ready);
    modport sink   (input valid, input found, input out_file_id,
                    input out_line_num, output ready);

endinterface

`default_nettype wire

FILE: src/bfh_ram.sv
// ----------------------------------------------------------------------------
// bfh_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module bfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/bfh_ring.sv
// ----------------------------------------------------------------------------
// bfh_ring
// One bounded ring stack. Entries live in a RAM; the newest-entry index and
// the fill count live in registers. The newest entry is read ahead of the op
// and then drives both the pop result and the duplicate check of a push.
// ----------------------------------------------------------------------------
`default_nettype none

module bfh_ring (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bfh_pkg::ring_ctl_t ctl,
    input  wire bfh_pkg::loc_t      push_loc,
    output bfh_pkg::ring_sts_t      sts
);

    import bfh_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    logic [IDX_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] top_inc, top_dec;
    logic             we;
    loc_t             rdata;
    logic             dup;

    // Neighbor indexes with wrap at the ring size.
    assign top_inc = (top_reg == LAST_IDX) ? '0 : top_reg + 1'b1;
    assign top_dec = (top_reg == '0) ? LAST_IDX : top_reg - 1'b1;

    // A push is dropped when the newest entry already holds the location.
    assign dup = (count_reg != '0) && (rdata == push_loc);

    // Index, count and write-enable update for the operation in flight.
    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        we         = 1'b0;
        if (ctl.fire)
        begin
            unique case (ctl.op)
                RING_PUSH:
                begin
                    if (!dup)
                    begin
                        top_next = top_inc;
                        we       = 1'b1;
                        if (count_reg != DEPTH_CNT)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                RING_POP:
                begin
                    if (count_reg != '0)
                    begin
                        top_next   = top_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
                RING_CLEAR:
                begin
                    count_next = '0;
                end
                RING_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    // Entry storage; a push overwrites the slot after the newest one.
    bfh_ram #(
        .WIDTH (LOC_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (top_inc),
        .wdata (push_loc),
        .re    (ctl.rd),
        .raddr (top_reg),
        .rdata (rdata)
    );

    assign sts.nonempty = (count_reg != '0);
    assign sts.top_data = rdata;

    // The fill count never passes the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("ring count above depth");

    // A pop on an empty ring leaves index and count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.op == RING_POP && count_reg == '0
        |=> $stable(top_reg) && count_reg == '0)
        else $error("pop on empty ring changed state");

endmodule

`default_nettype wire

FILE: src/back_forward_location_history.sv
// ----------------------------------------------------------------------------
// back_forward_location_history
// Back and forward ring stacks of locations. Record pushes onto back and
// empties forward; go back pops back and on a hit pushes the current
// location onto forward; go forward is the mirror.
//
//   channel  dir  word contents                       handshake
//   in_ch    in   cmd, file_id, line_num              valid/ready
//   out_ch   out  found, out_file_id, out_line_num    valid/ready
//
// Each command is accepted, which reads the newest entry of both ring RAMs
// into their registered read ports, and is then executed: S_EXEC checks,
// writes back and loads the result register. One result per command.
// A new command is taken while an earlier result still waits on out_ch;
// execution holds only while the result register is occupied and not taken.
// Reset clears ring indexes, fill counts and control; entry RAMs need no
// clearing pass, since an entry is read only behind a nonzero count.
// ----------------------------------------------------------------------------
`default_nettype none

module back_forward_location_history (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfh_in_if.sink     in_ch,
    bfh_out_if.source  out_ch
);

    import bfh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    loc_t             loc_reg;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    loc_t             out_loc_reg, out_loc_next;

    logic      accept;
    logic      exec_go;
    ring_ctl_t back_ctl, fwd_ctl;
    ring_sts_t back_sts, fwd_sts;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign exec_go     = (state_reg == S_EXEC) && (!out_valid_reg || out_ch.ready);

    // Ring operations for the command being executed.
    always_comb
    begin
        back_ctl.rd   = accept;
        back_ctl.fire = exec_go;
        back_ctl.op   = RING_NONE;
        fwd_ctl.rd    = accept;
        fwd_ctl.fire  = exec_go;
        fwd_ctl.op    = RING_NONE;
        found_next    = 1'b0;
        out_loc_next  = '0;
        unique case (cmd_reg)
            CMD_RECORD:
            begin
                back_ctl.op = RING_PUSH;
                fwd_ctl.op  = RING_CLEAR;
            end
            CMD_BACK:
            begin
                back_ctl.op = RING_POP;
                if (back_sts.nonempty)
                begin
                    fwd_ctl.op   = RING_PUSH;
                    found_next   = 1'b1;
                    out_loc_next = back_sts.top_data;
                end
            end
            CMD_FORWARD:
            begin
                fwd_ctl.op = RING_POP;
                if (fwd_sts.nonempty)
                begin
                    back_ctl.op  = RING_PUSH;
                    found_next   = 1'b1;
                    out_loc_next = fwd_sts.top_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured command word and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg          <= in_ch.cmd;
            loc_reg.file_id  <= in_ch.file_id;
            loc_reg.line_num <= in_ch.line_num;
        end
        if (exec_go)
        begin
            found_reg   <= found_next;
            out_loc_reg <= out_loc_next;
        end
    end

    bfh_ring u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (back_ctl),
        .push_loc (loc_reg),
        .sts      (back_sts)
    );

    bfh_ring u_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fwd_ctl),
        .push_loc (loc_reg),
        .sts      (fwd_sts)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.out_file_id  = out_loc_reg.file_id;
    assign out_ch.out_line_num = out_loc_reg.line_num;

    // An accepted word always moves on to execution.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    // Executing a command always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("executed command produced no result");

    // A miss returns an all-zero location.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> out_loc_reg == '0)
        else $error("miss carries a nonzero location");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the back/forward location history. Commands go in
// on the command channel. The bench keeps its own copy of both ring stacks
// and works out the location that each command should return. Returned words
// are checked field by field, in order. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb;

    import bfh_pkg::*;

    // The block ignores this command code; it must answer with a miss.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int BACK_RING    = 0;
    localparam int FWD_RING     = 1;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    // One returned word as the bench expects it.
    typedef struct packed {
        logic found;
        loc_t loc;
    } hist_result_t;

    logic clk;
    logic rst_n;

    bfh_in_if  cmd_ch ();
    bfh_out_if res_ch ();

    back_forward_location_history u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    // Shadow copy of the two rings, indexed by BACK_RING and FWD_RING.
    loc_t             ring_slot [2][HISTORY_DEPTH];
    logic [IDX_W-1:0] ring_top  [2];
    logic [CNT_W-1:0] ring_fill [2];

    hist_result_t expected_history[$];
    loc_t         hot_locs [4];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int words_sent;
    int results_seen;
    int hits_predicted;
    int wrap_pushes;
    int repeat_skips;

    // Clock with a 20 unit period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Push a location onto one ring; a repeat of the newest entry is dropped
    // and a full ring loses its oldest entry.
    function automatic void ring_push(input int id, input loc_t loc);
        if (ring_fill[id] != 0 && ring_slot[id][ring_top[id]] == loc)
        begin
            repeat_skips++;
            return;
        end
        ring_top[id] = (int'(ring_top[id]) == HISTORY_DEPTH - 1) ? '0 : ring_top[id] + 1'b1;
        if (ring_fill[id] < HISTORY_DEPTH)
            ring_fill[id]++;
        else
            wrap_pushes++;
        ring_slot[id][ring_top[id]] = loc;
    endfunction

    // Pop the newest entry of one ring, if there is one.
    function automatic void ring_pop(input int id, output logic hit, output loc_t loc);
        hit = 1'b0;
        loc = '0;
        if (ring_fill[id] != 0)
        begin
            hit = 1'b1;
            loc = ring_slot[id][ring_top[id]];
            ring_top[id] = (ring_top[id] == 0) ? IDX_W'(HISTORY_DEPTH - 1)
                                               : ring_top[id] - 1'b1;
            ring_fill[id]--;
        end
    endfunction

    // Apply one command to the shadow rings and return the expected word.
    function automatic hist_result_t predict_history(input logic [CMD_W-1:0] op,
                                                     input loc_t cur);
        hist_result_t res;
        loc_t         popped;
        logic         hit;
        res = '0;
        hit = 1'b0;
        popped = '0;
        case (op)
            CMD_RECORD:
            begin
                ring_fill[FWD_RING] = '0;
                ring_push(BACK_RING, cur);
            end
            CMD_BACK:
            begin
                ring_pop(BACK_RING, hit, popped);
                if (hit)
                    ring_push(FWD_RING, cur);
            end
            CMD_FORWARD:
            begin
                ring_pop(FWD_RING, hit, popped);
                if (hit)
                    ring_push(BACK_RING, cur);
            end
            default:
            begin
            end
        endcase
        res.found = hit;
        if (hit)
            res.loc = popped;
        return res;
    endfunction

    // Drive one command word, wait for it to be taken, and queue its answer.
    task automatic send_word(input logic [CMD_W-1:0] op, input loc_t cur);
        hist_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= op;
        cmd_ch.file_id  <= cur.file_id;
        cmd_ch.line_num <= cur.line_num;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        res = predict_history(op, cur);
        expected_history.push_back(res);
        words_sent++;
        if (res.found)
            hits_predicted++;
        @(negedge clk);
    endtask

    // Choose a command, leaning toward one kind for the length of a burst.
    function automatic logic [CMD_W-1:0] pick_command(input int mode);
        int               r;
        logic [CMD_W-1:0] lean;
        r = $urandom_range(99);
        lean = (mode == 0) ? CMD_RECORD : (mode == 1) ? CMD_BACK : CMD_FORWARD;
        if (r < 3)
            return CMD_UNUSED;
        if (mode != 3 && r < 75)
            return lean;
        r = $urandom_range(2);
        return (r == 0) ? CMD_RECORD : (r == 1) ? CMD_BACK : CMD_FORWARD;
    endfunction

    // Choose a location; reusing ring tops and a few hot locations makes
    // repeat pushes common.
    function automatic loc_t pick_location();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return hot_locs[$urandom_range(3)];
        if (r < 30 && ring_fill[BACK_RING] != 0)
            return ring_slot[BACK_RING][ring_top[BACK_RING]];
        if (r < 40 && ring_fill[FWD_RING] != 0)
            return ring_slot[FWD_RING][ring_top[FWD_RING]];
        return loc_t'($urandom);
    endfunction

    // Pops from both empty rings and the unused command, at field extremes.
    task automatic test_empty_history();
        send_word(CMD_BACK,    '{file_id: 8'hFF, line_num: 24'hFFFFFF});
        send_word(CMD_FORWARD, '{file_id: 8'h00, line_num: 24'h000000});
        send_word(CMD_UNUSED,  '{file_id: 8'hFF, line_num: 24'hFFFFFF});
    endtask

    // Record, walk back and forth, repeat pushes on both rings, and a record
    // that empties the forward ring.
    task automatic test_record_and_walk();
        loc_t loc_a;
        loc_t loc_b;
        loc_t loc_c;
        loc_t loc_d;
        loc_a = '{file_id: 8'h00, line_num: 24'h000000};
        loc_b = '{file_id: 8'hFF, line_num: 24'hFFFFFF};
        loc_c = '{file_id: 8'hAA, line_num: 24'h555555};
        loc_d = '{file_id: 8'h55, line_num: 24'hAAAAAA};
        send_word(CMD_RECORD,  loc_a);
        send_word(CMD_RECORD,  loc_b);
        send_word(CMD_RECORD,  loc_b);
        send_word(CMD_BACK,    loc_c);
        send_word(CMD_BACK,    loc_b);
        send_word(CMD_BACK,    loc_a);
        send_word(CMD_FORWARD, loc_a);
        send_word(CMD_FORWARD, loc_b);
        send_word(CMD_FORWARD, loc_d);
        send_word(CMD_BACK,    loc_c);
        send_word(CMD_BACK,    loc_c);
        send_word(CMD_RECORD,  loc_d);
        send_word(CMD_FORWARD, loc_a);
        send_word(CMD_UNUSED,  loc_c);
    endtask

    // Bursts of random traffic; each burst favors one command so that the
    // rings fill past their depth and drain to empty again.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_words);
        int               sent;
        int               burst_left;
        int               mode;
        logic [CMD_W-1:0] op;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        burst_left = 0;
        mode = 3;
        while (sent < n_words)
        begin
            if (burst_left == 0)
            begin
                mode = $urandom_range(3);
                burst_left = $urandom_range(40, 10);
            end
            op = pick_command(mode);
            send_word(op, pick_location());
            if (op != CMD_UNUSED)
                sent++;
            burst_left--;
        end
    endtask

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each returned word with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        hist_result_t want;
        hist_result_t got;
        string        bad;
        if (rst_n && (res_ch.valid & res_ch.ready) === 1'b1)
        begin
            results_seen++;
            got.found        = res_ch.found;
            got.loc.file_id  = res_ch.out_file_id;
            got.loc.line_num = res_ch.out_line_num;
            if (expected_history.size() == 0)
            begin
                want = '0;
                bad = "word with nothing expected";
            end
            else
            begin
                want = expected_history.pop_front();
                bad = "";
                if (got.found !== want.found)
                    bad = {bad, " found"};
                if (got.loc.file_id !== want.loc.file_id)
                    bad = {bad, " out_file_id"};
                if (got.loc.line_num !== want.loc.line_num)
                    bad = {bad, " out_line_num"};
            end
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on word %0d (%s): expected found=%0b file=%0d line=%0d, got found=%0b file=%0d line=%0d",
                             results_seen, bad, want.found, want.loc.file_id,
                             want.loc.line_num, got.found, got.loc.file_id,
                             got.loc.line_num);
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid & cmd_ch.ready) === 1'b1 ||
                (res_ch.valid & res_ch.ready) === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("No word moved for %0d cycles, %0d answers outstanding",
                 STALL_LIMIT, expected_history.size());
        $display("back_forward_location_history test failed");
        $finish;
    end

    // Test sequence.
    initial
    begin : main
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = CMD_RECORD;
        cmd_ch.file_id  = '0;
        cmd_ch.line_num = '0;
        res_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        send_idle_pct   = 10;
        recv_idle_pct   = 48;
        mismatches      = 0;
        words_sent      = 0;
        results_seen    = 0;
        hits_predicted  = 0;
        wrap_pushes     = 0;
        repeat_skips    = 0;
        for (int r = 0; r < 2; r++)
        begin
            ring_top[r]  = '0;
            ring_fill[r] = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                ring_slot[r][i] = '0;
        end
        for (int i = 0; i < 4; i++)
            hot_locs[i] = loc_t'($urandom);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_history();
        test_record_and_walk();
        test_random_traffic(10, 48, 540);
        test_random_traffic(48, 10, 540);
        test_random_traffic(0, 0, 520);

        // Let every outstanding answer come back, then idle before the final check.
        cmd_ch.valid <= 1'b0;
        while (expected_history.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_history.size() != 0)
            mismatches++;

        $display("Sent %0d commands and checked %0d answers, %0d of them returned locations.",
                 words_sent, results_seen, hits_predicted);
        $display("Rings overwrote their oldest entry %0d times and dropped %0d repeat pushes.",
                 wrap_pushes, repeat_skips);
        if (mismatches == 0)
            $display("back_forward_location_history test passed");
        else
            $display("back_forward_location_history test failed");
        $finish;
    end

endmodule
